>>> sv/bfla_pkg.sv
// shared types, constants and helpers for the free list block allocator
// no dependencies

package bfla_pkg;

    localparam int BLOCKS = 1024;
    localparam int ADDR_W = 11;
    localparam int IDX_W  = $clog2(BLOCKS);

    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [IDX_W-1:0]  t_idx;

    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } t_cmd_code;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_BAD  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LINK1,
        S_LINK2,
        S_LINK3,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic link1;
        logic link2;
        logic link3;
        logic finish;
    } t_dp_ctrl;

    typedef struct packed {
        logic err;
        logic is_free;
        logic out_busy;
    } t_dp_stat;

    function automatic logic in_range(input t_addr a);
        in_range = (a != '0) && (a <= ADDR_W'(BLOCKS));
    endfunction

    function automatic t_idx to_idx(input t_addr a);
        t_addr d;
        d = a - ADDR_W'(1);
        to_idx = d[IDX_W-1:0];
    endfunction

endpackage

>>> sv/bfla_if.sv
// request and response channel interfaces for the allocator
// depends on bfla_pkg

interface bfla_req_if import bfla_pkg::*; ();
    logic  valid;
    logic  ready;
    logic  command;
    t_addr block_address;

    modport source (output valid, command, block_address, input ready);
    modport sink   (input valid, command, block_address, output ready);
endinterface

interface bfla_rsp_if import bfla_pkg::*; ();
    logic    valid;
    logic    ready;
    t_status status;
    t_addr   address;
    t_addr   first_used;
    t_addr   last_used;
    t_addr   first_free;

    modport source (output valid, status, address, first_used, last_used, first_free,
                    input ready);
    modport sink   (input valid, status, address, first_used, last_used, first_free,
                    output ready);
endinterface

>>> sv/bfla_ram.sv
// generic simple dual port ram, one write and one registered read port
// no dependencies

module bfla_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/bfla_ctrl.sv
// sequencing state machine for allocate and free requests
// depends on bfla_pkg

module bfla_ctrl import bfla_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    output t_dp_ctrl o_ctrl
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_LINK1;
            end
            S_LINK1: begin
                n_state = i_stat.err ? S_DONE : S_LINK2;
            end
            S_LINK2: begin
                n_state = i_stat.is_free ? S_LINK3 : S_DONE;
            end
            S_LINK3: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!i_stat.out_busy) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_ctrl     = '0;
        case (r_state)
            S_IDLE: begin
                o_in_ready  = 1'b1;
                o_ctrl.load = i_in_valid;
            end
            S_LINK1: begin
                o_ctrl.link1 = !i_stat.err;
            end
            S_LINK2: begin
                o_ctrl.link2 = 1'b1;
            end
            S_LINK3: begin
                o_ctrl.link3 = 1'b1;
            end
            S_DONE: begin
                o_ctrl.finish = !i_stat.out_busy;
            end
            default: begin
                o_ctrl = '0;
            end
        endcase
    end

    a_ctrl_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_ctrl.load, o_ctrl.link1, o_ctrl.link2, o_ctrl.link3, o_ctrl.finish}))
        else $error("more than one datapath command");

    a_link1_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctrl.link1 |-> $past(o_ctrl.load))
        else $error("link step without a loaded request");

    a_link3_free_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctrl.link3 |-> i_stat.is_free)
        else $error("third link step on allocate");

endmodule

>>> sv/bfla_dp.sv
// datapath: link tables, chain heads, high-water mark and response register
// depends on bfla_pkg, bfla_if, bfla_ram

module bfla_dp import bfla_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_command,
    input  t_addr             i_block_address,
    input  t_dp_ctrl          i_ctrl,
    output t_dp_stat          o_stat,
    bfla_rsp_if.source        o_rsp
);

    t_cmd_code r_cmd;
    t_addr     r_addr;
    t_addr     r_used_head;
    t_addr     r_used_tail;
    t_addr     r_free_head;
    t_addr     r_high_water;
    logic      r_out_valid;
    t_status   r_status;
    t_addr     r_address;
    t_addr     r_first_used;
    t_addr     r_last_used;
    t_addr     r_first_free;

    t_addr     w_next_rd;
    t_addr     w_prev_rd;
    t_addr     w_rd_src;
    t_addr     w_op;
    logic      w_is_free;
    logic      w_full;
    logic      w_bad;
    logic      w_err;

    logic      w_nw_want;
    t_addr     w_nw_addr;
    t_addr     w_nw_data;
    logic      w_pw_want;
    t_addr     w_pw_addr;
    t_addr     w_pw_data;

    t_addr     n_used_head;
    t_addr     n_used_tail;
    t_addr     n_free_head;
    t_addr     n_high_water;

    assign w_rd_src = (t_cmd_code'(i_command) == CMD_FREE) ? i_block_address : r_free_head;

    bfla_ram #(.WIDTH(ADDR_W), .DEPTH(BLOCKS)) u_next_ram (
        .i_clk   (i_clk),
        .i_we    (w_nw_want && in_range(w_nw_addr)),
        .i_waddr (to_idx(w_nw_addr)),
        .i_wdata (w_nw_data),
        .i_re    (i_ctrl.load),
        .i_raddr (to_idx(w_rd_src)),
        .o_rdata (w_next_rd)
    );

    bfla_ram #(.WIDTH(ADDR_W), .DEPTH(BLOCKS)) u_prev_ram (
        .i_clk   (i_clk),
        .i_we    (w_pw_want && in_range(w_pw_addr)),
        .i_waddr (to_idx(w_pw_addr)),
        .i_wdata (w_pw_data),
        .i_re    (i_ctrl.load),
        .i_raddr (to_idx(w_rd_src)),
        .o_rdata (w_prev_rd)
    );

    assign w_is_free = (r_cmd == CMD_FREE);
    assign w_full    = !w_is_free && (r_free_head == '0) &&
                       (r_high_water >= ADDR_W'(BLOCKS));
    assign w_bad     = w_is_free && !in_range(r_addr);
    assign w_err     = w_full || w_bad;
    assign w_op      = w_is_free ? r_addr :
                       (r_free_head != '0) ? r_free_head : r_high_water + ADDR_W'(1);

    assign o_stat.err      = w_err;
    assign o_stat.is_free  = w_is_free;
    assign o_stat.out_busy = r_out_valid && !o_rsp.ready;

    // link table writes, in the order the chains are relinked
    always_comb begin
        w_nw_want = 1'b0;
        w_nw_addr = w_op;
        w_nw_data = '0;
        w_pw_want = 1'b0;
        w_pw_addr = w_op;
        w_pw_data = '0;
        if (w_is_free) begin
            if (i_ctrl.link1) begin
                w_nw_want = (w_prev_rd != '0);
                w_nw_addr = w_prev_rd;
                w_nw_data = w_next_rd;
                w_pw_want = (w_next_rd != '0);
                w_pw_addr = w_next_rd;
                w_pw_data = w_prev_rd;
            end else if (i_ctrl.link2) begin
                w_nw_want = 1'b1;
                w_nw_data = r_free_head;
                w_pw_want = 1'b1;
            end else if (i_ctrl.link3) begin
                w_pw_want = (r_free_head != '0);
                w_pw_addr = r_free_head;
                w_pw_data = w_op;
            end
        end else begin
            if (i_ctrl.link1) begin
                w_nw_want = 1'b1;
                w_pw_want = (r_free_head != '0) && (w_next_rd != '0);
                w_pw_addr = w_next_rd;
            end else if (i_ctrl.link2) begin
                w_pw_want = 1'b1;
                w_pw_data = r_used_tail;
                w_nw_want = (r_used_tail != '0);
                w_nw_addr = r_used_tail;
                w_nw_data = w_op;
            end
        end
    end

    always_comb begin
        n_used_head  = r_used_head;
        n_used_tail  = r_used_tail;
        n_free_head  = r_free_head;
        n_high_water = r_high_water;
        if (!w_err) begin
            if (w_is_free) begin
                if (w_prev_rd == '0) n_used_head = w_next_rd;
                if (w_next_rd == '0) n_used_tail = w_prev_rd;
                n_free_head = w_op;
            end else begin
                if (r_free_head != '0) begin
                    n_free_head = w_next_rd;
                end else begin
                    n_high_water = w_op;
                end
                if (r_used_tail == '0) n_used_head = w_op;
                n_used_tail = w_op;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_cmd  <= t_cmd_code'(i_command);
            r_addr <= i_block_address;
        end
        if (i_ctrl.finish) begin
            r_status     <= w_full ? ST_FULL : (w_bad ? ST_BAD : ST_OK);
            r_address    <= w_err ? '0 : w_op;
            r_first_used <= n_used_head;
            r_last_used  <= n_used_tail;
            r_first_free <= n_free_head;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used_head  <= '0;
            r_used_tail  <= '0;
            r_free_head  <= '0;
            r_high_water <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_ctrl.finish) begin
                r_used_head  <= n_used_head;
                r_used_tail  <= n_used_tail;
                r_free_head  <= n_free_head;
                r_high_water <= n_high_water;
                r_out_valid  <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.status     = r_status;
    assign o_rsp.address    = r_address;
    assign o_rsp.first_used = r_first_used;
    assign o_rsp.last_used  = r_last_used;
    assign o_rsp.first_free = r_first_free;

    a_hw_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_high_water <= ADDR_W'(BLOCKS))
        else $error("high-water mark past the store");

    a_err_no_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.finish && w_err |=> $stable(r_high_water) && $stable(r_free_head)
                                   && $stable(r_used_head) && $stable(r_used_tail))
        else $error("failed request changed the chains");

    a_finish_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.finish |-> !r_out_valid || o_rsp.ready)
        else $error("response overwritten before it was taken");

endmodule

>>> sv/block_free_list_allocator_top.sv
// top level of the free list block allocator
// depends on bfla_pkg, bfla_if, bfla_ctrl, bfla_dp (and bfla_ram below it)
//
// usage: a request beat on i_req carries a command (allocate or free) and,
// for free, a block number 1..BLOCKS. each request gives exactly one
// response beat on o_rsp: status, the block handed out or released, and the
// heads and tail of the in-use and free chains after the request.
// after the beat is loaded in idle, allocate steps through link1, link2 and done,
// free also through link3, and a full store or a bad address skips from link1 to done.
// one request is in work at a time: a new request is taken only once the last one
// has left its done step. the steps are set by the single write port of each of
// the two link tables, which the relinking steps share.
// the response sits in an output register: while it waits the next request
// is still taken and worked on, and only its last step holds until the
// receiver takes the waiting beat.
// after reset both chains are empty and the high-water mark is zero; the
// link tables are not cleared and need no clearing pass.

module block_free_list_allocator_top import bfla_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bfla_req_if.sink    i_req,
    bfla_rsp_if.source  o_rsp
);

    t_dp_ctrl w_ctrl;
    t_dp_stat w_stat;

    bfla_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .i_stat     (w_stat),
        .o_ctrl     (w_ctrl)
    );

    bfla_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_command       (i_req.command),
        .i_block_address (i_req.block_address),
        .i_ctrl          (w_ctrl),
        .o_stat          (w_stat),
        .o_rsp           (o_rsp)
    );

endmodule

>>> tb/tb_block_free_list_allocator_top.sv
// self-checking testbench for block_free_list_allocator_top: directed table, then random phases
// predicts the in-use and free chains in step with the block; depends on bfla_pkg and bfla_if

module tb_block_free_list_allocator_top;
    import bfla_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 500000;

    typedef struct packed {
        t_status status;
        t_addr   address;
        t_addr   first_used;
        t_addr   last_used;
        t_addr   first_free;
    } t_rsp_beat;

    typedef struct packed {
        t_cmd_code cmd;
        t_addr     blk;
        logic      typed;
        t_rsp_beat want;
    } t_dir_row;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_PERIODIC
    } t_rx_mode;

    localparam t_dir_row DIR_ROWS [21] = '{
        '{CMD_FREE,  11'd0,     1'b1, '{ST_BAD, 11'd0, 11'd0, 11'd0, 11'd0}},
        '{CMD_FREE,  11'd2047,  1'b1, '{ST_BAD, 11'd0, 11'd0, 11'd0, 11'd0}},
        '{CMD_FREE,  11'd1025,  1'b1, '{ST_BAD, 11'd0, 11'd0, 11'd0, 11'd0}},
        '{CMD_ALLOC, 11'd2047,  1'b1, '{ST_OK,  11'd1, 11'd1, 11'd1, 11'd0}},
        '{CMD_ALLOC, 11'd0,     1'b1, '{ST_OK,  11'd2, 11'd1, 11'd2, 11'd0}},
        '{CMD_ALLOC, 11'h555,   1'b1, '{ST_OK,  11'd3, 11'd1, 11'd3, 11'd0}},
        '{CMD_ALLOC, 11'h2aa,   1'b1, '{ST_OK,  11'd4, 11'd1, 11'd4, 11'd0}},
        '{CMD_FREE,  11'd2,     1'b0, '0},
        '{CMD_FREE,  11'd1,     1'b0, '0},
        '{CMD_FREE,  11'd4,     1'b0, '0},
        '{CMD_FREE,  11'd3,     1'b0, '0},
        '{CMD_ALLOC, 11'd0,     1'b0, '0},
        '{CMD_ALLOC, 11'h7ff,   1'b0, '0},
        '{CMD_ALLOC, 11'd0,     1'b0, '0},
        '{CMD_FREE,  11'd0,     1'b0, '0},
        '{CMD_ALLOC, 11'd0,     1'b0, '0},
        '{CMD_ALLOC, 11'd0,     1'b0, '0},
        '{CMD_FREE,  11'd5,     1'b0, '0},
        '{CMD_FREE,  11'd3,     1'b0, '0},
        '{CMD_FREE,  11'd1,     1'b0, '0},
        '{CMD_ALLOC, 11'd0,     1'b0, '0}
    };

    logic i_clk;
    logic i_rst_n;

    bfla_req_if req_ch ();
    bfla_rsp_if rsp_ch ();

    block_free_list_allocator_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    t_addr       nxt_tab [1:BLOCKS];
    t_addr       prv_tab [1:BLOCKS];
    t_addr       m_used_head = '0;
    t_addr       m_used_tail = '0;
    t_addr       m_free_head = '0;
    int unsigned m_high_water = 0;

    t_addr       live_q [$];
    bit          is_live [1:BLOCKS];
    t_rsp_beat   pending_rsp [$];

    int          burst_left = 0;
    int          err_cnt = 0;
    int          cycle_cnt = 0;

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic t_addr nxt_of(input t_addr a);
        return (a != '0 && a <= BLOCKS) ? nxt_tab[a] : '0;
    endfunction

    function automatic t_addr prv_of(input t_addr a);
        return (a != '0 && a <= BLOCKS) ? prv_tab[a] : '0;
    endfunction

    function automatic void set_nxt(input t_addr a, input t_addr v);
        if (a != '0 && a <= BLOCKS) nxt_tab[a] = v;
    endfunction

    function automatic void set_prv(input t_addr a, input t_addr v);
        if (a != '0 && a <= BLOCKS) prv_tab[a] = v;
    endfunction

    function automatic t_rsp_beat predict_chains(input t_cmd_code cmd, input t_addr blk);
        t_rsp_beat r;
        t_addr     a;
        t_addr     rest;
        t_addr     nb;
        t_addr     pb;
        r = '0;
        a = '0;
        if (cmd == CMD_ALLOC) begin
            if (m_free_head != '0) begin
                a = m_free_head;
                rest = nxt_of(a);
                if (rest != '0) set_prv(rest, '0);
                m_free_head = rest;
            end else if (m_high_water < BLOCKS) begin
                m_high_water++;
                a = t_addr'(m_high_water);
            end else begin
                r.status = ST_FULL;
            end
            if (r.status == ST_OK) begin
                set_prv(a, m_used_tail);
                set_nxt(a, '0);
                if (m_used_tail != '0) set_nxt(m_used_tail, a);
                else m_used_head = a;
                m_used_tail = a;
            end
        end else if (blk == '0 || blk > BLOCKS) begin
            r.status = ST_BAD;
        end else begin
            nb = nxt_of(blk);
            pb = prv_of(blk);
            if (nb != '0) begin
                if (pb != '0) begin
                    set_nxt(pb, nb);
                    set_prv(nb, pb);
                end else begin
                    m_used_head = nb;
                    set_prv(nb, '0);
                end
            end else if (pb != '0) begin
                set_nxt(pb, '0);
                m_used_tail = pb;
            end else begin
                m_used_head = '0;
                m_used_tail = '0;
            end
            set_nxt(blk, m_free_head);
            set_prv(blk, '0);
            if (m_free_head != '0) set_prv(m_free_head, blk);
            m_free_head = blk;
            a = blk;
        end
        r.address    = a;
        r.first_used = m_used_head;
        r.last_used  = m_used_tail;
        r.first_free = m_free_head;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input t_addr got, input t_addr want);
        $display("mismatch at cycle %0d: %s got %0d want %0d", cycle_cnt, what, got, want);
        err_cnt++;
    endtask

    // called at a falling edge, returns at a falling edge after the beat is taken
    task automatic send_req(input t_cmd_code cmd, input t_addr blk, input logic typed,
                            input t_rsp_beat want);
        t_rsp_beat pred;
        req_ch.valid         <= 1'b1;
        req_ch.command       <= cmd;
        req_ch.block_address <= blk;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        pred = predict_chains(cmd, blk);
        pending_rsp.push_back(typed ? want : pred);
        if (pred.status == ST_OK) begin
            if (cmd == CMD_ALLOC) begin
                live_q.push_back(pred.address);
                is_live[pred.address] = 1'b1;
            end else if (is_live[blk]) begin
                is_live[blk] = 1'b0;
                for (int i = 0; i < live_q.size(); i++) begin
                    if (live_q[i] == blk) begin
                        live_q.delete(i);
                        break;
                    end
                end
            end
        end
        @(negedge i_clk);
    endtask

    task automatic pace_sender();
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
    endtask

    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        while (pending_rsp.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    // stray frees hit blocks that may already sit on the free chain
    task automatic run_mix(input int items, input int alloc_pct, input int bad_pct,
                           input bit stray);
        int        roll;
        t_addr     blk;
        t_cmd_code cmd;
        repeat (items) begin
            roll = $urandom_range(0, 99);
            cmd  = CMD_FREE;
            blk  = t_addr'($urandom);
            if (roll < bad_pct) begin
                blk = ($urandom_range(0, 3) == 0) ? '0
                      : t_addr'($urandom_range(BLOCKS + 1, 2**ADDR_W - 1));
            end else if (roll < bad_pct + alloc_pct || m_high_water == 0) begin
                cmd = CMD_ALLOC;
            end else if (stray && $urandom_range(0, 1) == 1) begin
                blk = t_addr'($urandom_range(1, m_high_water));
            end else if (live_q.size() != 0) begin
                blk = live_q[$urandom_range(0, live_q.size() - 1)];
            end else begin
                cmd = CMD_ALLOC;
            end
            pace_sender();
            send_req(cmd, blk, 1'b0, '0);
        end
    endtask

    initial begin
        t_rx_mode rx_mode;
        int       rx_left;
        rsp_ch.ready = 1'b0;
        rx_mode = RX_OPEN;
        rx_left = 0;
        forever begin
            @(negedge i_clk);
            if (rx_left == 0) begin
                rx_mode = t_rx_mode'($urandom_range(0, 3));
                rx_left = $urandom_range(32, 200);
            end else begin
                rx_left--;
            end
            if (!i_rst_n) begin
                rsp_ch.ready <= 1'b0;
            end else begin
                case (rx_mode)
                    RX_OPEN:   rsp_ch.ready <= 1'b1;
                    RX_COIN:   rsp_ch.ready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
                    default:   rsp_ch.ready <= ((rx_left % 8) > 1);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        t_rsp_beat want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (pending_rsp.size() == 0) begin
                report_mismatch("beat with nothing pending, address", rsp_ch.address, '0);
            end else begin
                want = pending_rsp.pop_front();
                if (rsp_ch.status !== want.status)
                    report_mismatch("status", t_addr'(rsp_ch.status), t_addr'(want.status));
                if (rsp_ch.address !== want.address)
                    report_mismatch("address", rsp_ch.address, want.address);
                if (rsp_ch.first_used !== want.first_used)
                    report_mismatch("first_used", rsp_ch.first_used, want.first_used);
                if (rsp_ch.last_used !== want.last_used)
                    report_mismatch("last_used", rsp_ch.last_used, want.last_used);
                if (rsp_ch.first_free !== want.first_free)
                    report_mismatch("first_free", rsp_ch.first_free, want.first_free);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("timeout with %0d beats pending", pending_rsp.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        req_ch.valid         = 1'b0;
        req_ch.command       = CMD_ALLOC;
        req_ch.block_address = '0;
        i_rst_n              = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (DIR_ROWS[i]) begin
            pace_sender();
            send_req(DIR_ROWS[i].cmd, DIR_ROWS[i].blk, DIR_ROWS[i].typed, DIR_ROWS[i].want);
        end
        wait_drained();

        run_mix(300, 50, 4, 1'b0);
        wait_drained();

        // fill the store, then knock on it while full
        while (!(m_high_water == BLOCKS && m_free_head == '0)) run_mix(1, 95, 2, 1'b0);
        run_mix(24, 100, 0, 1'b0);
        wait_drained();

        pace_sender();
        send_req(CMD_FREE, t_addr'(BLOCKS), 1'b0, '0);
        run_mix(400, 30, 3, 1'b0);
        wait_drained();

        run_mix(60, 45, 5, 1'b1);
        wait_drained();

        if (err_cnt == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
